@@ src/embedding_match_or_assign_table_unit_defines.svh @@
// ----------------------------------------------------------------------------
// embedding match-or-assign table: assertion macros
// shared property shapes for the table unit, clocked on i_clk, held off in reset
// ----------------------------------------------------------------------------
`ifndef EMBEDDING_MATCH_OR_ASSIGN_TABLE_UNIT_DEFINES_SVH
`define EMBEDDING_MATCH_OR_ASSIGN_TABLE_UNIT_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define EMT_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("emt: invariant violated");

// antecedent implies consequent in the same cycle
`define EMT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("emt: implication violated");

`endif

@@ src/emt_pkg.sv @@
// ----------------------------------------------------------------------------
// emt_pkg
// sizes, command codes and shared types of the embedding match-or-assign table
// ----------------------------------------------------------------------------
`default_nettype none

package emt_pkg;

    // table geometry
    localparam int DIM         = 128;
    localparam int MAX_ENTRIES = 256;
    localparam int ELEM_WIDTH  = 16;
    localparam int ID_W        = 16;

    localparam int POS_W  = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int ENT_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W = ENT_W + POS_W;

    // distance arithmetic, units of 2^-28
    localparam int THR_W = 40;
    localparam int ACC_W = THR_W + 1;
    localparam int DIF_W = ELEM_WIDTH + 1;
    localparam int SQ_W  = 2 * DIF_W;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(96636764);
    localparam logic [ACC_W-1:0] DIST_CAP  = ACC_W'(1) << THR_W;

    // command codes
    localparam logic [1:0] CMD_QUERY = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // result of one embedding
    typedef struct packed {
        logic [ID_W-1:0] face_id;
        logic            matched;
        logic            created;
        logic            table_full;
    } t_result;

    // memory control from the sequencer to the storage
    typedef struct packed {
        logic                  q_we;
        logic [POS_W-1:0]      q_waddr;
        logic [ELEM_WIDTH-1:0] q_wdata;
        logic [POS_W-1:0]      q_raddr;
        logic [ADDR_W-1:0]     s_raddr;
        logic                  s_we;
        logic [ADDR_W-1:0]     s_waddr;
        logic                  id_we;
        logic [ENT_W-1:0]      id_waddr;
        logic [ID_W-1:0]       id_wdata;
        logic [ENT_W-1:0]      id_raddr;
    } t_store_ctrl;

    // multiply-accumulate unit status
    typedef struct packed {
        logic busy;
    } t_mac_status;

endpackage

`default_nettype wire

@@ src/embedding_match_or_assign_table_unit.sv @@
// ----------------------------------------------------------------------------
// embedding_match_or_assign_table_unit: top level and sequencer
// query walks entries to the first hit, else copies into a new entry, as a preload does
// throughput: one embedding at a time, bound by the one shared multiply-accumulate
// reset: sync active-low clears state, count, position; threshold to 0.6 squared
// ----------------------------------------------------------------------------
`default_nettype none
`include "embedding_match_or_assign_table_unit_defines.svh"

module embedding_match_or_assign_table_unit
    import emt_pkg::*;
(
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // input transactions
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire        [1:0]             i_cmd,
    input  wire signed [ELEM_WIDTH-1:0]  i_element,
    input  wire                          i_last,
    input  wire        [ID_W-1:0]        i_entry_id,
    // result transactions
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic       [ID_W-1:0]        o_face_id,
    output logic                         o_matched,
    output logic                         o_created,
    output logic                         o_table_full,
    // threshold register write
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire        [THR_W-1:0]       i_cfg_data
);

    // sequencer states
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_WALK    = 3'd1;
    localparam logic [2:0] S_DRAIN   = 3'd2;
    localparam logic [2:0] S_CHECK   = 3'd3;
    localparam logic [2:0] S_IDWAIT  = 3'd4;
    localparam logic [2:0] S_COPY    = 3'd5;
    localparam logic [2:0] S_COPYEND = 3'd6;
    localparam logic [2:0] S_RESULT  = 3'd7;

    logic [2:0]        r_state,     n_state;
    logic [POS_W-1:0]  r_pos,       n_pos;
    logic [CNT_W-1:0]  r_count,     n_count;
    logic [ENT_W-1:0]  r_ent,       n_ent;
    logic [POS_W-1:0]  r_idx,       n_idx;
    logic              r_cp_v,      n_cp_v;
    logic [POS_W-1:0]  r_cp_idx,    n_cp_idx;
    logic [ID_W-1:0]   r_new_id,    n_new_id;
    t_result           r_res,       n_res;
    logic              r_out_valid, n_out_valid;
    t_result           r_out,       n_out;
    logic [THR_W-1:0]  r_thr;

    logic                         accept;
    logic                         full;
    logic                         last_ent;
    logic                         hit;
    logic                         out_load;
    logic                         issue;
    logic                         acc_clear;
    t_store_ctrl                  st_ctrl;
    t_mac_status                  mac_status;
    logic signed [ELEM_WIDTH-1:0] q_elem;
    logic signed [ELEM_WIDTH-1:0] s_elem;
    logic        [ID_W-1:0]       id_rdata;
    logic        [ACC_W-1:0]      acc;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_in_valid && !o_in_stall;
    assign full        = (r_count >= CNT_W'(MAX_ENTRIES));
    assign last_ent    = ((CNT_W'(r_ent) + CNT_W'(1)) == r_count);
    assign hit         = (ACC_W'(r_thr) > acc);
    assign out_load    = (r_state == S_RESULT) && (!r_out_valid || !i_out_stall);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_count   = r_count;
        n_ent     = r_ent;
        n_idx     = r_idx;
        n_cp_v    = 1'b0;
        n_cp_idx  = r_idx;
        n_new_id  = r_new_id;
        n_res     = r_res;
        issue     = 1'b0;
        acc_clear = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_cmd == CMD_CLEAR) begin
                        n_count = '0;
                        n_pos   = '0;
                    end else if (i_cmd == CMD_QUERY || i_cmd == CMD_LOAD) begin
                        if (!i_last) begin
                            n_pos = (r_pos == POS_W'(DIM - 1)) ? '0 : r_pos + POS_W'(1);
                        end else begin
                            n_pos = '0;
                            n_idx = '0;
                            if (i_cmd == CMD_QUERY && r_count != '0) begin
                                n_ent     = '0;
                                acc_clear = 1'b1;
                                n_state   = S_WALK;
                            end else if (full) begin
                                n_res   = '{face_id: '0, matched: 1'b0, created: 1'b0,
                                            table_full: 1'b1};
                                n_state = S_RESULT;
                            end else begin
                                n_new_id = (i_cmd == CMD_LOAD) ? i_entry_id : ID_W'(r_count);
                                n_state  = S_COPY;
                            end
                        end
                    end
                end
            end
            // one element pair per cycle into the accumulator
            S_WALK: begin
                issue = 1'b1;
                if (r_idx == POS_W'(DIM - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + POS_W'(1);
                end
            end
            S_DRAIN: begin
                if (!mac_status.busy) begin
                    n_state = S_CHECK;
                end
            end
            // first entry below threshold wins
            S_CHECK: begin
                n_idx = '0;
                if (hit) begin
                    n_state = S_IDWAIT;
                end else if (!last_ent) begin
                    n_ent     = r_ent + ENT_W'(1);
                    acc_clear = 1'b1;
                    n_state   = S_WALK;
                end else if (full) begin
                    n_res   = '{face_id: '0, matched: 1'b0, created: 1'b0, table_full: 1'b1};
                    n_state = S_RESULT;
                end else begin
                    n_new_id = ID_W'(r_count);
                    n_state  = S_COPY;
                end
            end
            S_IDWAIT: begin
                n_res   = '{face_id: id_rdata, matched: 1'b1, created: 1'b0,
                            table_full: 1'b0};
                n_state = S_RESULT;
            end
            // copy the query buffer into the next free entry
            S_COPY: begin
                n_cp_v   = 1'b1;
                n_cp_idx = r_idx;
                if (r_idx == POS_W'(DIM - 1)) begin
                    n_state = S_COPYEND;
                end else begin
                    n_idx = r_idx + POS_W'(1);
                end
            end
            S_COPYEND: begin
                n_count = r_count + CNT_W'(1);
                n_res   = '{face_id: r_new_id, matched: 1'b0, created: 1'b1,
                            table_full: 1'b0};
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register, freed when the transaction is taken
    always_comb begin
        n_out = r_out;
        if (out_load) begin
            n_out       = r_res;
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_count     <= '0;
            r_cp_v      <= 1'b0;
            r_out_valid <= 1'b0;
            r_thr       <= THR_RESET;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_cp_v      <= n_cp_v;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
        end
    end

    // payload and index registers
    always_ff @(posedge i_clk) begin
        r_ent    <= n_ent;
        r_idx    <= n_idx;
        r_cp_idx <= n_cp_idx;
        r_new_id <= n_new_id;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    // memory control
    always_comb begin
        st_ctrl.q_we     = accept && (i_cmd == CMD_QUERY || i_cmd == CMD_LOAD);
        st_ctrl.q_waddr  = r_pos;
        st_ctrl.q_wdata  = unsigned'(i_element);
        st_ctrl.q_raddr  = r_idx;
        st_ctrl.s_raddr  = {r_ent, r_idx};
        st_ctrl.s_we     = r_cp_v;
        st_ctrl.s_waddr  = {r_count[ENT_W-1:0], r_cp_idx};
        st_ctrl.id_we    = (r_state == S_COPYEND);
        st_ctrl.id_waddr = r_count[ENT_W-1:0];
        st_ctrl.id_wdata = r_new_id;
        st_ctrl.id_raddr = r_ent;
    end

    emt_store u_store (
        .i_clk    (i_clk),
        .i_ctrl   (st_ctrl),
        .o_q_elem (q_elem),
        .o_s_elem (s_elem),
        .o_id     (id_rdata)
    );

    emt_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (issue),
        .i_clear  (acc_clear),
        .i_q_elem (q_elem),
        .i_s_elem (s_elem),
        .o_acc    (acc),
        .o_status (mac_status)
    );

    assign o_out_valid  = r_out_valid;
    assign o_face_id    = r_out.face_id;
    assign o_matched    = r_out.matched;
    assign o_created    = r_out.created;
    assign o_table_full = r_out.table_full;

    // checks on the sequencer
    `EMT_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(MAX_ENTRIES))
    `EMT_ASSERT_IMPL(a_check_after_drain, r_state == S_CHECK, !mac_status.busy)
    `EMT_ASSERT_IMPL(a_load_from_result, $rose(o_out_valid), $past(r_state) == S_RESULT)
    `EMT_ASSERT_IMPL(a_count_grows_on_copy, r_count > $past(r_count), $past(r_state) == S_COPYEND)
    `EMT_ASSERT_IMPL(a_one_outcome, o_out_valid, $countones({o_matched, o_created, o_table_full}) == 1)

endmodule

`default_nettype wire

@@ src/emt_store.sv @@
// ----------------------------------------------------------------------------
// emt_store
// query buffer, embedding store and identity store, registered read ports;
// a copy writes the embedding store from the query buffer read data
// ----------------------------------------------------------------------------
`default_nettype none

module emt_store
    import emt_pkg::*;
(
    input  wire                          i_clk,
    input  wire t_store_ctrl             i_ctrl,
    output logic signed [ELEM_WIDTH-1:0] o_q_elem,
    output logic signed [ELEM_WIDTH-1:0] o_s_elem,
    output logic        [ID_W-1:0]       o_id
);

    logic [ELEM_WIDTH-1:0] r_qbuf [DIM];
    logic [ELEM_WIDTH-1:0] r_emb  [MAX_ENTRIES * DIM];
    logic [ID_W-1:0]       r_ids  [MAX_ENTRIES];

    logic [ELEM_WIDTH-1:0] r_q_rdata;
    logic [ELEM_WIDTH-1:0] r_s_rdata;
    logic [ID_W-1:0]       r_id_rdata;

    // query buffer: one write, one read
    always_ff @(posedge i_clk) begin
        if (i_ctrl.q_we) begin
            r_qbuf[i_ctrl.q_waddr] <= i_ctrl.q_wdata;
        end
        r_q_rdata <= r_qbuf[i_ctrl.q_raddr];
    end

    // embedding store: copy writes take the query read data
    always_ff @(posedge i_clk) begin
        if (i_ctrl.s_we) begin
            r_emb[i_ctrl.s_waddr] <= r_q_rdata;
        end
        r_s_rdata <= r_emb[i_ctrl.s_raddr];
    end

    // identity store
    always_ff @(posedge i_clk) begin
        if (i_ctrl.id_we) begin
            r_ids[i_ctrl.id_waddr] <= i_ctrl.id_wdata;
        end
        r_id_rdata <= r_ids[i_ctrl.id_raddr];
    end

    assign o_q_elem = $signed(r_q_rdata);
    assign o_s_elem = $signed(r_s_rdata);
    assign o_id     = r_id_rdata;

endmodule

`default_nettype wire

@@ src/emt_mac.sv @@
// ----------------------------------------------------------------------------
// emt_mac
// shared squared-difference accumulator: subtract, square, saturating add,
// one element pair per cycle behind the memory read latency
// ----------------------------------------------------------------------------
`default_nettype none

module emt_mac
    import emt_pkg::*;
(
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_issue,
    input  wire                          i_clear,
    input  wire signed [ELEM_WIDTH-1:0]  i_q_elem,
    input  wire signed [ELEM_WIDTH-1:0]  i_s_elem,
    output logic       [ACC_W-1:0]       o_acc,
    output t_mac_status                  o_status
);

    logic                    r_v0;
    logic                    r_v1;
    logic                    r_v2;
    logic signed [DIF_W-1:0] r_diff;
    logic        [SQ_W-1:0]  r_sq;
    logic        [ACC_W-1:0] r_acc;
    logic signed [SQ_W-1:0]  prod;
    logic        [ACC_W:0]   sum;

    // valid tags follow the read data through the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    // difference then square, a register after each
    assign prod = r_diff * r_diff;

    always_ff @(posedge i_clk) begin
        r_diff <= DIF_W'(i_s_elem) - DIF_W'(i_q_elem);
        r_sq   <= unsigned'(prod);
    end

    // accumulate, saturating at the distance cap
    assign sum = (ACC_W + 1)'(r_acc) + (ACC_W + 1)'(r_sq);

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_v2) begin
            if (sum >= (ACC_W + 1)'(DIST_CAP)) begin
                r_acc <= DIST_CAP;
            end else begin
                r_acc <= sum[ACC_W-1:0];
            end
        end
    end

    assign o_acc         = r_acc;
    assign o_status.busy = r_v0 | r_v1 | r_v2;

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: embedding match-or-assign table testbench
// drives element, preload, clear and ignored transactions into the table unit
// and checks every result against a shadow copy of the table. a fixed-point
// squared-distance search over the shadow entries predicts each outcome.
// directed tests cover the first full embedding, exact and boundary matches,
// threshold extremes, mixed and overlong embeddings, a full table and a long
// output hold-off; random traffic then runs under four idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import emt_pkg::*;

    // code that the block drops without effect
    localparam logic [1:0] CMD_IGNORED = 2'd3;
    localparam longint SUM_CAP  = longint'(1) << THR_W;
    localparam longint TERM_CAP = longint'(1) << 20;
    localparam logic [THR_W-1:0] THR_MAX = '1;

    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         i_in_valid   = 1'b0;
    logic                         o_in_stall;
    logic        [1:0]            i_cmd        = CMD_QUERY;
    logic signed [ELEM_WIDTH-1:0] i_element    = '0;
    logic                         i_last       = 1'b0;
    logic        [ID_W-1:0]       i_entry_id   = '0;
    logic                         o_out_valid;
    logic                         i_out_stall  = 1'b0;
    logic        [ID_W-1:0]       o_face_id;
    logic                         o_matched;
    logic                         o_created;
    logic                         o_table_full;
    logic                         i_cfg_valid  = 1'b0;
    logic                         o_cfg_ready;
    logic        [THR_W-1:0]      i_cfg_data   = '0;

    // shadow copy of the table state
    logic signed [ELEM_WIDTH-1:0] shadow_query [DIM];
    logic signed [ELEM_WIDTH-1:0] shadow_store [MAX_ENTRIES][DIM];
    logic        [ID_W-1:0]       shadow_ids   [MAX_ENTRIES];
    int                           shadow_count = 0;
    int                           shadow_pos   = 0;
    logic        [THR_W-1:0]      shadow_threshold = THR_RESET;

    t_result awaited_outcomes [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int fault_count   = 0;
    int counted_items = 0;
    int matches_seen  = 0;
    int entries_made  = 0;
    int refusals_seen = 0;
    int clears_seen   = 0;

    embedding_match_or_assign_table_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_element    (i_element),
        .i_last       (i_last),
        .i_entry_id   (i_entry_id),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_face_id    (o_face_id),
        .o_matched    (o_matched),
        .o_created    (o_created),
        .o_table_full (o_table_full),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // squared distance of one stored entry to the collected embedding, saturating
    function automatic longint entry_distance(int entry);
        longint sum;
        longint diff;
        longint mag;
        sum = 0;
        for (int i = 0; i < DIM; i++) begin
            diff = longint'(shadow_store[entry][i]) - longint'(shadow_query[i]);
            mag  = (diff < 0) ? -diff : diff;
            if (mag >= TERM_CAP) return SUM_CAP;
            sum += mag * mag;
            if (sum >= SUM_CAP) return SUM_CAP;
        end
        return sum;
    endfunction

    // apply one accepted transaction to the shadow table, queue its outcome
    function automatic void fold_into_shadow_table(logic [1:0] cmd,
                                                   logic signed [ELEM_WIDTH-1:0] elem,
                                                   logic last, logic [ID_W-1:0] id);
        t_result outcome;
        int      slot;
        if (cmd == CMD_IGNORED) return;
        counted_items++;
        if (cmd == CMD_CLEAR) begin
            shadow_count = 0;
            shadow_pos   = 0;
            clears_seen++;
            return;
        end
        shadow_query[shadow_pos] = elem;
        if (!last) begin
            shadow_pos = (shadow_pos + 1) % DIM;
            return;
        end
        shadow_pos = 0;
        outcome    = '0;
        slot       = -1;
        if (cmd == CMD_QUERY) begin
            for (int e = 0; e < shadow_count && slot < 0; e++)
                if (entry_distance(e) < longint'(shadow_threshold)) slot = e;
        end
        if (slot >= 0) begin
            outcome.face_id = shadow_ids[slot];
            outcome.matched = 1'b1;
            matches_seen++;
        end else if (shadow_count >= MAX_ENTRIES) begin
            outcome.table_full = 1'b1;
            refusals_seen++;
        end else begin
            outcome.face_id = (cmd == CMD_QUERY) ? ID_W'(shadow_count) : id;
            outcome.created = 1'b1;
            for (int i = 0; i < DIM; i++) shadow_store[shadow_count][i] = shadow_query[i];
            shadow_ids[shadow_count] = outcome.face_id;
            shadow_count++;
            entries_made++;
        end
        awaited_outcomes = {awaited_outcomes, outcome};
    endfunction

    // element close to the buffered one, or anywhere in range
    function automatic logic signed [ELEM_WIDTH-1:0] pick_element();
        int v;
        if ($urandom_range(99) < 50) begin
            v = int'(shadow_query[shadow_pos]) + int'($urandom_range(6000)) - 3000;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
        end else begin
            case ($urandom_range(9))
                0:       v = -32768;
                1:       v = 32767;
                default: v = int'($urandom_range(65535)) - 32768;
            endcase
        end
        return ELEM_WIDTH'(v);
    endfunction

    // offer one transaction, with a random idle gap ahead of it
    task automatic send_item(input logic [1:0] cmd, input logic signed [ELEM_WIDTH-1:0] elem,
                             input logic last, input logic [ID_W-1:0] id);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_element  <= elem;
        i_last     <= last;
        i_entry_id <= id;
        do @(posedge i_clk); while (o_in_stall);
        fold_into_shadow_table(cmd, elem, last, id);
    endtask

    // one embedding of len elements; mixed varies the leading commands,
    // abandon replaces the closing element with a clear
    task automatic send_embedding(input logic [1:0] final_cmd, input int len,
                                  input bit mixed, input bit abandon);
        logic [1:0] cmd;
        for (int k = 0; k < len; k++) begin
            cmd = final_cmd;
            if (k < len - 1 && mixed) cmd = $urandom_range(1) ? CMD_QUERY : CMD_LOAD;
            if (k == len - 1 && abandon)
                send_item(CMD_CLEAR, pick_element(), 1'($urandom), 16'($urandom));
            else
                send_item(cmd, pick_element(), k == len - 1, 16'($urandom));
        end
    endtask

    // stop offering and wait until the block has drained and gone quiet
    task automatic settle_block();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_outcomes.size() != 0);
        repeat (DIM + 8) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        shadow_threshold = value;
    endtask

    // full first embedding with extreme elements, then exact match and far query
    task automatic test_first_fill_and_exact_match();
        logic signed [ELEM_WIDTH-1:0] v;
        for (int i = 0; i < DIM; i++) begin
            case (i % 5)
                0:       v = -32768;
                1:       v = 32767;
                2:       v = 0;
                3:       v = -1;
                default: v = 16'($urandom);
            endcase
            send_item(CMD_LOAD, v, i == DIM - 1, 16'hFFFF);
        end
        send_item(CMD_QUERY, shadow_query[0], 1'b1, 16'h0000);
        send_item(CMD_QUERY, 16'sh7FFF, 1'b1, 16'h0000);
        send_item(CMD_LOAD, 16'sh0000, 1'b1, 16'h0000);
    endtask

    // ignored command inside an embedding leaves position and table alone
    task automatic test_ignored_command();
        send_item(CMD_QUERY, 16'sh1234, 1'b0, 16'h0000);
        send_item(CMD_IGNORED, 16'sh7FFF, 1'b1, 16'hFFFF);
        send_item(CMD_IGNORED, -16'sd32768, 1'b0, 16'h0000);
        send_item(CMD_QUERY, -16'sd1234, 1'b1, 16'h0000);
    endtask

    // threshold equal to the distance, one above it, zero and maximum
    task automatic test_threshold_edges();
        logic signed [ELEM_WIDTH-1:0] probe;
        logic signed [ELEM_WIDTH-1:0] saved;
        longint                       gap;
        settle_block();
        saved = shadow_query[0];
        probe = (saved > 0) ? saved - 16'sd1000 : saved + 16'sd1000;
        shadow_query[0] = probe;
        gap = entry_distance(0);
        shadow_query[0] = saved;
        write_threshold(THR_W'(gap));
        send_item(CMD_QUERY, probe, 1'b1, 16'h0000);
        settle_block();
        write_threshold(THR_W'(gap + 1));
        send_item(CMD_QUERY, probe, 1'b1, 16'h0000);
        settle_block();
        write_threshold('0);
        send_item(CMD_QUERY, probe, 1'b1, 16'h0000);
        settle_block();
        write_threshold(THR_MAX);
        send_item(CMD_QUERY, 16'sh4000, 1'b1, 16'h0000);
        settle_block();
        write_threshold(THR_RESET);
    endtask

    // clear with either last, mixed commands, clear inside an embedding
    task automatic test_clear_and_mixed_commands();
        send_item(CMD_CLEAR, 16'sh0000, 1'b0, 16'h0000);
        send_item(CMD_QUERY, 16'sh0100, 1'b1, 16'h0000);
        send_item(CMD_CLEAR, -16'sd1, 1'b1, 16'hFFFF);
        send_item(CMD_QUERY, 16'sh2000, 1'b0, 16'h0000);
        send_item(CMD_QUERY, -16'sd8192, 1'b0, 16'h0000);
        send_item(CMD_LOAD, 16'sh0555, 1'b1, 16'h5A5A);
        send_item(CMD_LOAD, 16'sh0AAA, 1'b0, 16'h0000);
        send_item(CMD_QUERY, 16'sh2000, 1'b1, 16'hA5A5);
        send_item(CMD_QUERY, 16'sh3000, 1'b0, 16'h0000);
        send_item(CMD_CLEAR, 16'sh0000, 1'b0, 16'h0000);
        send_item(CMD_QUERY, -16'sd3000, 1'b1, 16'h0000);
    endtask

    // more elements than DIM wrap the position back over the start
    task automatic test_overlong_embedding();
        for (int i = 0; i < DIM + 3; i++)
            send_item(CMD_QUERY, 16'($urandom), i == DIM + 2, 16'($urandom));
    endtask

    // fill every entry, then refuse a query and a preload, then match entry zero
    task automatic test_table_full();
        logic [ID_W-1:0] id;
        send_item(CMD_CLEAR, 16'sh0000, 1'b1, 16'h0000);
        for (int k = 0; k < MAX_ENTRIES; k++) begin
            id = (k == 0) ? 16'h0000 : (k == MAX_ENTRIES - 1) ? 16'hFFFF : 16'($urandom);
            send_item(CMD_LOAD, ELEM_WIDTH'(k * 256 - 32768), 1'b1, id);
        end
        settle_block();
        write_threshold('0);
        send_item(CMD_QUERY, 16'sh1111, 1'b1, 16'h0000);
        send_item(CMD_LOAD, 16'sh2222, 1'b1, 16'hBEEF);
        settle_block();
        write_threshold(THR_MAX);
        send_item(CMD_QUERY, 16'sh3333, 1'b1, 16'h0000);
        settle_block();
        write_threshold(THR_RESET);
        send_item(CMD_CLEAR, 16'sh0000, 1'b0, 16'h0000);
    endtask

    // receiver holds off for a long stretch while embeddings keep coming
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_item(CMD_CLEAR, 16'sh0000, 1'b1, 16'h0000);
        hold_left = 1500;
        for (int n = 0; n < 16; n++)
            send_embedding(n[0] ? CMD_LOAD : CMD_QUERY, 2, 1'b0, 1'b0);
        settle_block();
    endtask

    // random embeddings, clears and noise under one idling mix
    task automatic test_random_traffic(input int quota, input int idle_pct, input int hold_pct,
                                       input logic [THR_W-1:0] thr);
        int start;
        int roll;
        int len;
        settle_block();
        write_threshold(thr);
        send_idle_pct = idle_pct;
        stall_pct     = hold_pct;
        start         = counted_items;
        while (counted_items - start < quota) begin
            roll = $urandom_range(99);
            len  = ($urandom_range(99) < 85) ? $urandom_range(1, 4) : $urandom_range(5, 24);
            if (shadow_count >= 14 || roll < 5)
                send_item(CMD_CLEAR, pick_element(), 1'($urandom), 16'($urandom));
            else if (roll < 9)
                send_item(CMD_IGNORED, pick_element(), 1'($urandom), 16'($urandom));
            else if (roll < 13)
                send_embedding(CMD_QUERY, len + 1, 1'b1, 1'b1);
            else
                send_embedding(roll < 66 ? CMD_QUERY : CMD_LOAD, len, roll % 7 == 0, 1'b0);
        end
    endtask

    // output stall, with a counted long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // compare each result transaction with the oldest outcome waiting
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_outcomes.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("unexpected result: face_id %h matched %b created %b full %b",
                             o_face_id, o_matched, o_created, o_table_full);
            end else begin
                want = awaited_outcomes.pop_front();
                if (o_face_id !== want.face_id || o_matched !== want.matched ||
                    o_created !== want.created || o_table_full !== want.table_full) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("result mismatch at %0t: face_id %h/%h matched %b/%b %s%b/%b %s%b/%b",
                                 $realtime, want.face_id, o_face_id, want.matched, o_matched,
                                 "created ", want.created, o_created,
                                 "full ", want.table_full, o_table_full);
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 20;
        stall_pct     = 20;
        test_first_fill_and_exact_match();
        test_ignored_command();
        test_threshold_edges();
        test_clear_and_mixed_commands();
        test_overlong_embedding();
        test_table_full();
        test_output_backpressure();
        test_random_traffic(45, 0, 0, THR_RESET);
        test_random_traffic(45, 72, 0, THR_W'($urandom_range(200_000_000)));
        test_random_traffic(45, 0, 72, THR_RESET);
        test_random_traffic(45, 38, 38, {8'($urandom_range(3)), 32'($urandom)});
        settle_block();
        $display("covered %0d transactions: %0d matches, %0d new entries, %0d refusals",
                 counted_items, matches_seen, entries_made, refusals_seen);
        $display("with %0d clears, zero to full-scale thresholds and four idling mixes",
                 clears_seen);
        if (fault_count == 0 && awaited_outcomes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
